// File: rtl/hcb_pkg.sv
package hcb_pkg;

    // Alphabet and field sizes
    localparam int ALPHABET   = 256;
    localparam int MAXSYM     = 256;
    localparam int COUNT_BITS = 24;
    localparam int SYM_W      = 8;
    localparam int NODE_W     = 9;
    localparam int NODE_DEPTH = 512;
    localparam int WEIGHT_W   = 32;
    localparam int CODE_W     = 64;
    localparam int LEN_W      = 6;
    localparam int LEAF_W     = 9;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 2;

    // Memory word widths
    localparam int HEAP_W  = WEIGHT_W + NODE_W;  // {weight, node}
    localparam int CHILD_W = 2 * NODE_W;         // {left, right}
    localparam int WORK_W  = CODE_W + LEN_W;     // {code, length}

    // Stream payload widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USED_W = STATUS_W + CODE_W + LEN_W + LEAF_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT  = 2'd0,
        KIND_BUILD  = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_ABSENT = 2'd2
    } status_t;

    // Datapath micro-operations
    typedef enum logic [5:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_CLEAR,
        OP_BLD_EMPTY,
        OP_BLD_INIT,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_INS_TOP,
        OP_INS_CMP,
        OP_X_RD0,
        OP_X_RDL,
        OP_X_LAST,
        OP_SD_L,
        OP_SD_R,
        OP_SD_STEP,
        OP_SAVE_A,
        OP_MERGE,
        OP_ROOT_RD,
        OP_TR_ROOT,
        OP_TR_RD,
        OP_TR_WA,
        OP_TR_WB,
        OP_BLD_DONE,
        OP_LK_MISS,
        OP_LK_RD,
        OP_LK_HIT,
        OP_RESP
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CNT_RD,
        S_CNT_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_TEST,
        S_INS_TOP,
        S_INS_CMP,
        S_INS_DONE,
        S_MERGE_CHK,
        S_X_RD0,
        S_X_RDL,
        S_X_LAST,
        S_SD_L,
        S_SD_R,
        S_SD_STEP,
        S_X_DONE,
        S_MERGE,
        S_ROOT_RD,
        S_TR_ROOT,
        S_TR_CHK,
        S_TR_RD,
        S_TR_WA,
        S_TR_WB,
        S_LK_HIT,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  leaf_zero;
        logic  codes_ok;
        logic  lk_hit;
        logic  scan_nz;
        logic  scan_end;
        logic  ins_root;
        logic  ins_up;
        logic  sd_l_ok;
        logic  sd_move;
        logic  heap_multi;
        logic  tr_done;
        logic  out_free;
    } dp_stat_t;

endpackage

// File: rtl/hcb_ram.sv
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds without re
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hcb_ctrl.sv
module hcb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hcb_pkg::dp_stat_t stat,
    output hcb_pkg::dp_cmd_t  cmd
);
    import hcb_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        merge_phase_reg, merge_phase_next;   // insert called from merge loop
    logic        second_reg, second_next;             // second extract of a pair

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            merge_phase_reg <= 1'b0;
            second_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            merge_phase_reg <= merge_phase_next;
            second_reg      <= second_next;
        end
    end

    // Next state and datapath command
    always_comb begin
        state_next       = state_reg;
        merge_phase_next = merge_phase_reg;
        second_next      = second_reg;
        cmd.op           = OP_NONE;
        s_tready         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.kind)
                    KIND_COUNT: state_next = S_CNT_RD;
                    KIND_BUILD: begin
                        if (stat.leaf_zero) begin
                            cmd.op     = OP_BLD_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            cmd.op           = OP_BLD_INIT;
                            merge_phase_next = 1'b0;
                            state_next       = S_SCAN_RD;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (stat.codes_ok) begin
                            cmd.op     = OP_LK_RD;
                            state_next = S_LK_HIT;
                        end else begin
                            cmd.op     = OP_LK_MISS;
                            state_next = S_RESP;
                        end
                    end
                    default: begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CNT_RD: begin
                cmd.op     = OP_CNT_RD;
                state_next = S_CNT_WR;
            end
            S_CNT_WR: begin
                cmd.op     = OP_CNT_WR;
                state_next = S_RESP;
            end
            // Load present symbols into the heap
            S_SCAN_RD: begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.op     = OP_SCAN_CHK;
                state_next = stat.scan_nz ? S_INS_TOP : S_SCAN_TEST;
            end
            S_SCAN_TEST: begin
                state_next = stat.scan_end ? S_MERGE_CHK : S_SCAN_RD;
            end
            // Sift-up insert
            S_INS_TOP: begin
                cmd.op     = OP_INS_TOP;
                state_next = stat.ins_root ? S_INS_DONE : S_INS_CMP;
            end
            S_INS_CMP: begin
                cmd.op     = OP_INS_CMP;
                state_next = stat.ins_up ? S_INS_TOP : S_INS_DONE;
            end
            S_INS_DONE: begin
                state_next = merge_phase_reg ? S_MERGE_CHK : S_SCAN_TEST;
            end
            // Merge loop
            S_MERGE_CHK: begin
                second_next = 1'b0;
                state_next  = stat.heap_multi ? S_X_RD0 : S_ROOT_RD;
            end
            S_X_RD0: begin
                cmd.op     = OP_X_RD0;
                state_next = S_X_RDL;
            end
            S_X_RDL: begin
                cmd.op     = OP_X_RDL;
                state_next = S_X_LAST;
            end
            S_X_LAST: begin
                cmd.op     = OP_X_LAST;
                state_next = S_SD_L;
            end
            S_SD_L: begin
                cmd.op     = OP_SD_L;
                state_next = stat.sd_l_ok ? S_SD_R : S_X_DONE;
            end
            S_SD_R: begin
                cmd.op     = OP_SD_R;
                state_next = S_SD_STEP;
            end
            S_SD_STEP: begin
                cmd.op     = OP_SD_STEP;
                state_next = stat.sd_move ? S_SD_L : S_X_DONE;
            end
            S_X_DONE: begin
                if (!second_reg) begin
                    cmd.op      = OP_SAVE_A;
                    second_next = 1'b1;
                    state_next  = S_X_RD0;
                end else begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                cmd.op           = OP_MERGE;
                merge_phase_next = 1'b1;
                state_next       = S_INS_TOP;
            end
            // Code assignment, parents before children
            S_ROOT_RD: begin
                cmd.op     = OP_ROOT_RD;
                state_next = S_TR_ROOT;
            end
            S_TR_ROOT: begin
                cmd.op     = OP_TR_ROOT;
                state_next = S_TR_CHK;
            end
            S_TR_CHK: begin
                if (stat.tr_done) begin
                    cmd.op     = OP_BLD_DONE;
                    state_next = S_RESP;
                end else begin
                    state_next = S_TR_RD;
                end
            end
            S_TR_RD: begin
                cmd.op     = OP_TR_RD;
                state_next = S_TR_WA;
            end
            S_TR_WA: begin
                cmd.op     = OP_TR_WA;
                state_next = S_TR_WB;
            end
            S_TR_WB: begin
                cmd.op     = OP_TR_WB;
                state_next = S_TR_CHK;
            end
            // Present bit and code read back; absent symbol answers a miss
            S_LK_HIT: begin
                cmd.op     = stat.lk_hit ? OP_LK_HIT : OP_LK_MISS;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.op     = OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/hcb_dp.sv
module hcb_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hcb_pkg::dp_cmd_t                  cmd,
    input  logic [hcb_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [hcb_pkg::KIND_W-1:0]        s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [hcb_pkg::OUT_DATA_W-1:0]    m_tdata,
    output hcb_pkg::dp_stat_t                 stat
);
    import hcb_pkg::*;

    // Transaction and control registers
    kind_t                  kind_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic [MAXSYM-1:0]      cnt_vld_reg;
    logic [LEAF_W-1:0]      leaf_reg;
    logic                   codes_valid_reg;
    logic [SYM_W:0]         scan_reg;
    logic [NODE_W-1:0]      hsz_reg;
    logic [NODE_W-1:0]      next_reg;
    logic [SYM_W-1:0]       i_reg;
    logic                   rv_reg;
    logic [HEAP_W-1:0]      e_reg;
    logic [HEAP_W-1:0]      l_reg;
    logic [HEAP_W-1:0]      top_reg;
    logic [HEAP_W-1:0]      a_reg;
    status_t                res_status_reg;
    logic [CODE_W-1:0]      res_code_reg;
    logic [LEN_W-1:0]       res_len_reg;
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    // Memory ports
    logic                   cnt_we, cnt_re;
    logic [SYM_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata;
    logic                   heap_we, heap_re;
    logic [SYM_W-1:0]       heap_waddr, heap_raddr;
    logic [HEAP_W-1:0]      heap_wdata, heap_rdata;
    logic                   child_we, child_re;
    logic [SYM_W-1:0]       child_waddr, child_raddr;
    logic [CHILD_W-1:0]     child_wdata, child_rdata;
    logic                   work_we, work_re;
    logic [NODE_W-1:0]      work_waddr, work_raddr;
    logic [WORK_W-1:0]      work_wdata, work_rdata;
    logic                   pres_we, pres_re;
    logic [SYM_W-1:0]       pres_waddr, pres_raddr;
    logic                   pres_wdata, pres_rdata;

    // Derived values
    logic [SYM_W-1:0]       cnt_idx;
    logic [COUNT_BITS-1:0]  cnt_cur;
    logic                   sym_ok;
    logic [SYM_W:0]         lidx, ridx;
    logic                   l_ok, r_ok;
    logic [SYM_W-1:0]       parent_idx;
    logic                   ins_up;
    logic [HEAP_W-1:0]      small_e;
    logic [SYM_W-1:0]       small_idx;
    logic                   sd_move;
    logic [WEIGHT_W-1:0]    sum_w;
    logic [CODE_W-1:0]      code_shl;
    logic [LEN_W-1:0]       len_inc;

    hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAXSYM)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    hcb_ram #(.WIDTH(HEAP_W), .DEPTH(MAXSYM)) u_heap_ram (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .re(heap_re), .raddr(heap_raddr), .rdata(heap_rdata)
    );
    hcb_ram #(.WIDTH(CHILD_W), .DEPTH(MAXSYM)) u_child_ram (
        .aclk(aclk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
        .re(child_re), .raddr(child_raddr), .rdata(child_rdata)
    );
    hcb_ram #(.WIDTH(WORK_W), .DEPTH(NODE_DEPTH)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .re(work_re), .raddr(work_raddr), .rdata(work_rdata)
    );
    // Present bit per symbol, all written by every build scan
    hcb_ram #(.WIDTH(1), .DEPTH(MAXSYM)) u_pres_ram (
        .aclk(aclk), .we(pres_we), .waddr(pres_waddr), .wdata(pres_wdata),
        .re(pres_re), .raddr(pres_raddr), .rdata(pres_rdata)
    );

    // Count entry seen through its valid bit
    assign cnt_idx = (cmd.op == OP_SCAN_CHK) ? scan_reg[SYM_W-1:0] : sym_reg;
    assign cnt_cur = cnt_vld_reg[cnt_idx] ? cnt_rdata : '0;
    assign sym_ok  = ({1'b0, sym_reg} < (SYM_W+1)'(ALPHABET));

    // Heap index arithmetic
    assign lidx       = {i_reg, 1'b1};
    assign ridx       = lidx + (SYM_W+1)'(1);
    assign l_ok       = lidx < hsz_reg;
    assign r_ok       = ridx < hsz_reg;
    assign parent_idx = (i_reg - SYM_W'(1)) >> 1;
    assign ins_up     = e_reg[HEAP_W-1:NODE_W] < heap_rdata[HEAP_W-1:NODE_W];

    // Sift-down: smaller of hole entry, left and right, strict less-than
    always_comb begin
        small_e   = e_reg;
        small_idx = i_reg;
        sd_move   = 1'b0;
        if (l_reg[HEAP_W-1:NODE_W] < e_reg[HEAP_W-1:NODE_W]) begin
            small_e   = l_reg;
            small_idx = lidx[SYM_W-1:0];
            sd_move   = 1'b1;
        end
        if (rv_reg && (heap_rdata[HEAP_W-1:NODE_W] < small_e[HEAP_W-1:NODE_W])) begin
            small_e   = heap_rdata;
            small_idx = ridx[SYM_W-1:0];
            sd_move   = 1'b1;
        end
    end

    assign sum_w    = a_reg[HEAP_W-1:NODE_W] + top_reg[HEAP_W-1:NODE_W];
    assign code_shl = work_rdata[WORK_W-1:LEN_W] << 1;
    assign len_inc  = work_rdata[LEN_W-1:0] + LEN_W'(1);

    // Memory controls
    always_comb begin
        cnt_we      = 1'b0;
        cnt_re      = 1'b0;
        cnt_waddr   = sym_reg;
        cnt_raddr   = sym_reg;
        cnt_wdata   = cnt_cur + COUNT_BITS'(1);
        heap_we     = 1'b0;
        heap_re     = 1'b0;
        heap_waddr  = i_reg;
        heap_raddr  = parent_idx;
        heap_wdata  = e_reg;
        child_we    = 1'b0;
        child_re    = 1'b0;
        child_waddr = next_reg[SYM_W-1:0];
        child_raddr = next_reg[SYM_W-1:0] - SYM_W'(1);
        child_wdata = {a_reg[NODE_W-1:0], top_reg[NODE_W-1:0]};
        work_we     = 1'b0;
        work_re     = 1'b0;
        work_waddr  = child_rdata[CHILD_W-1:NODE_W];
        work_raddr  = next_reg - NODE_W'(1);
        work_wdata  = {code_shl, len_inc};
        pres_we     = 1'b0;
        pres_re     = 1'b0;
        pres_waddr  = scan_reg[SYM_W-1:0];
        pres_raddr  = sym_reg;
        pres_wdata  = (cnt_cur != '0);
        case (cmd.op)
            OP_CNT_RD: cnt_re = 1'b1;
            OP_CNT_WR: cnt_we = sym_ok && (cnt_cur != COUNT_MAX);
            OP_SCAN_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = scan_reg[SYM_W-1:0];
            end
            OP_SCAN_CHK: pres_we = 1'b1;
            OP_INS_TOP: begin
                heap_we = (i_reg == '0);
                heap_re = (i_reg != '0);
            end
            OP_INS_CMP: begin
                heap_we = 1'b1;
                if (ins_up) begin
                    heap_wdata = heap_rdata;
                end
            end
            OP_X_RD0: begin
                heap_re    = 1'b1;
                heap_raddr = '0;
            end
            OP_X_RDL: begin
                heap_re    = 1'b1;
                heap_raddr = SYM_W'(hsz_reg - NODE_W'(1));
            end
            OP_SD_L: begin
                heap_re    = l_ok;
                heap_raddr = lidx[SYM_W-1:0];
                heap_we    = !l_ok;
            end
            OP_SD_R: begin
                heap_re    = r_ok;
                heap_raddr = ridx[SYM_W-1:0];
            end
            OP_SD_STEP: begin
                heap_we    = 1'b1;
                heap_wdata = small_e;
            end
            OP_MERGE: child_we = 1'b1;
            OP_ROOT_RD: begin
                heap_re    = 1'b1;
                heap_raddr = '0;
            end
            OP_TR_ROOT: begin
                work_we    = 1'b1;
                work_waddr = heap_rdata[NODE_W-1:0];
                work_wdata = '0;
            end
            OP_TR_RD: begin
                work_re  = 1'b1;
                child_re = 1'b1;
            end
            OP_TR_WA: work_we = 1'b1;
            OP_TR_WB: begin
                work_we    = 1'b1;
                work_waddr = child_rdata[NODE_W-1:0];
                work_wdata = {code_shl | CODE_W'(1), len_inc};
            end
            OP_LK_RD: begin
                work_re    = 1'b1;
                work_raddr = {1'b0, sym_reg};
                pres_re    = 1'b1;
            end
            default: ;
        endcase
    end

    // Control state: cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg     <= '0;
            leaf_reg        <= '0;
            codes_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.op == OP_RESP) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CNT_WR: begin
                    if (sym_ok && (cnt_cur != COUNT_MAX)) begin
                        cnt_vld_reg[sym_reg] <= 1'b1;
                        if (cnt_cur == '0) begin
                            leaf_reg <= leaf_reg + LEAF_W'(1);
                        end
                    end
                end
                OP_CLEAR: begin
                    cnt_vld_reg     <= '0;
                    leaf_reg        <= '0;
                    codes_valid_reg <= 1'b0;
                end
                OP_BLD_EMPTY: codes_valid_reg <= 1'b0;
                OP_BLD_DONE:  codes_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                kind_reg       <= kind_t'(s_tuser);
                sym_reg        <= s_tdata[SYM_W-1:0];
                res_status_reg <= STAT_OK;
                res_code_reg   <= '0;
                res_len_reg    <= '0;
            end
            OP_BLD_EMPTY: res_status_reg <= STAT_EMPTY;
            OP_LK_MISS:   res_status_reg <= STAT_ABSENT;
            OP_LK_HIT: begin
                res_code_reg <= work_rdata[WORK_W-1:LEN_W];
                res_len_reg  <= work_rdata[LEN_W-1:0];
            end
            OP_BLD_INIT: begin
                hsz_reg  <= '0;
                scan_reg <= '0;
                next_reg <= NODE_W'(MAXSYM);
            end
            OP_SCAN_CHK: begin
                scan_reg <= scan_reg + (SYM_W+1)'(1);
                if (cnt_cur != '0) begin
                    e_reg   <= {WEIGHT_W'(cnt_cur), {1'b0, scan_reg[SYM_W-1:0]}};
                    i_reg   <= hsz_reg[SYM_W-1:0];
                    hsz_reg <= hsz_reg + NODE_W'(1);
                end
            end
            OP_INS_CMP: begin
                if (ins_up) begin
                    i_reg <= parent_idx;
                end
            end
            OP_X_RDL: top_reg <= heap_rdata;
            OP_X_LAST: begin
                e_reg   <= heap_rdata;
                hsz_reg <= hsz_reg - NODE_W'(1);
                i_reg   <= '0;
            end
            OP_SD_R: begin
                l_reg  <= heap_rdata;
                rv_reg <= r_ok;
            end
            OP_SD_STEP: i_reg <= small_idx;
            OP_SAVE_A:  a_reg <= top_reg;
            OP_MERGE: begin
                e_reg    <= {sum_w, next_reg};
                i_reg    <= hsz_reg[SYM_W-1:0];
                hsz_reg  <= hsz_reg + NODE_W'(1);
                next_reg <= next_reg + NODE_W'(1);
            end
            OP_TR_RD: next_reg <= next_reg - NODE_W'(1);
            OP_RESP: begin
                m_data_reg <= {(OUT_DATA_W-OUT_USED_W)'(0), leaf_reg, res_len_reg,
                               res_code_reg, res_status_reg};
            end
            default: ;
        endcase
    end

    // Status to the controller
    always_comb begin
        stat.kind       = kind_reg;
        stat.leaf_zero  = (leaf_reg == '0);
        stat.codes_ok   = codes_valid_reg && sym_ok;
        stat.lk_hit     = pres_rdata;
        stat.scan_nz    = (cnt_cur != '0);
        stat.scan_end   = (scan_reg == (SYM_W+1)'(ALPHABET));
        stat.ins_root   = (i_reg == '0);
        stat.ins_up     = ins_up;
        stat.sd_l_ok    = l_ok;
        stat.sd_move    = sd_move;
        stat.heap_multi = (hsz_reg > NODE_W'(1));
        stat.tr_done    = (next_reg == NODE_W'(MAXSYM));
        stat.out_free   = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/huffman_code_builder.sv
// Build: scans every alphabet symbol and inserts each present one into the heap by
// sift-up, merges the two smallest heap extracts (each a sift-down) into an inner
// tree node until one is left, then assigns codes per inner tree node.
// Throughput: one transaction at a time; a new one is taken while a result waits.
// Reset: synchronous, active low; counts and codes become empty at once, no sweep.
module huffman_code_builder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hcb_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] symbol
    input  logic [hcb_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [65:2] code_bits, [71:66] code_length, [80:72] leaf_count
    output logic [hcb_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import hcb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    hcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .stat     (stat)
    );

endmodule
